FILE: design/bsba_pkg.sv
// ============================================================================
// bsba_pkg
// Shared types and constants of the bass and arpeggio loop synthesizer.
// ============================================================================
package bsba_pkg;

    // Default build options, handed to the top level as parameter defaults.
    localparam int unsigned SAMPLE_RATE_DEF    = 48000;
    localparam int unsigned SINE_ADDR_BITS_DEF = 10;
    localparam int unsigned ENV_ADDR_BITS_DEF  = 8;

    // Configuration port.
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_BEAT_STEP  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_BEATS = 1'd1;

    localparam logic [31:0] BEAT_STEP_RST  = 32'd178957;
    localparam logic [10:0] LOOP_BEATS_RST = 11'd16;

    // Stream widths.
    localparam int unsigned S_TDATA_W = 8;
    localparam int unsigned M_TDATA_W = 16;

    // Operands handed from the sequencer to the mixer.
    typedef struct packed {
        logic signed [15:0] sb;   // bass sine
        logic signed [15:0] so;   // bass octave sine
        logic signed [15:0] sa;   // arpeggio sine
        logic        [15:0] env;  // decay level, unsigned Q1.15
    } t_mix_in;

endpackage

FILE: design/bsba_sine_rom.sv
// ============================================================================
// bsba_sine_rom
// Quarter-wave sine ROM with quadrant folding and a registered read.
// ============================================================================
module bsba_sine_rom
    import bsba_pkg::*;
#(
    parameter int unsigned SINE_ADDR_BITS = SINE_ADDR_BITS_DEF
) (
    input  logic               i_clk,
    input  logic [31:0]        i_phase,
    output logic signed [15:0] o_value
);

    localparam int unsigned SINE_N = 1 << SINE_ADDR_BITS;
    localparam logic [63:0] PI_Q30   = 64'd3373259426;
    localparam logic [63:0] SINE_DEN = 64'(4 * SINE_N);
    localparam logic [63:0] SINE_RND = 64'(2 * SINE_N);
    localparam logic [63:0] SIN_DIV [1:7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                              64'd110, 64'd156, 64'd210};

    // Taylor series of sin at the middle of entry k, in Q30.
    function automatic logic [15:0] sine_entry(input int unsigned k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] mag;
        logic [63:0] sum;
        logic [63:0] v;
        x   = (PI_Q30 * (64'(2 * k) + 64'd1) + SINE_RND) / SINE_DEN;
        x2  = (x * x) >> 30;
        mag = x;
        sum = x;
        for (int n = 1; n <= 7; n++) begin
            mag = ((mag * x2) >> 30) / SIN_DIV[n];
            if ((n % 2) == 1) begin
                sum = sum - mag;
            end else begin
                sum = sum + mag;
            end
        end
        v = (sum * 64'd32768 + 64'd536870912) >> 30;
        return (v > 64'd32767) ? 16'd32767 : v[15:0];
    endfunction

    logic [15:0] rom [SINE_N];

    for (genvar k = 0; k < SINE_N; k++) begin : g_rom
        assign rom[k] = sine_entry(k);
    end

    logic [1:0]                quad;
    logic [SINE_ADDR_BITS-1:0] idx;
    logic [15:0]               r_data;
    logic                      r_neg;

    assign quad = i_phase[31:30];
    // Odd quadrants run the table backwards: N-1-i is the bitwise inverse.
    assign idx  = quad[0] ? ~i_phase[29 -: SINE_ADDR_BITS] : i_phase[29 -: SINE_ADDR_BITS];

    always_ff @(posedge i_clk) begin
        r_data <= rom[idx];
        r_neg  <= quad[1];
    end

    assign o_value = r_neg ? -$signed(r_data) : $signed(r_data);

endmodule

FILE: design/bsba_env_rom.sv
// ============================================================================
// bsba_env_rom
// Decay envelope ROM, exp(-3x) over one beat, with a registered read.
// ============================================================================
module bsba_env_rom
    import bsba_pkg::*;
#(
    parameter int unsigned ENV_ADDR_BITS = ENV_ADDR_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [ENV_ADDR_BITS-1:0] i_addr,
    output logic [15:0]              o_level
);

    localparam int unsigned ENV_N = 1 << ENV_ADDR_BITS;
    localparam logic [63:0] ENV_DEN = 64'(8 * ENV_N);
    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
    localparam logic [63:0] ENV_DIV [1:10] = '{64'd1, 64'd2, 64'd3, 64'd4, 64'd5,
                                               64'd6, 64'd7, 64'd8, 64'd9, 64'd10};

    // exp(-z) by series at an eighth of the argument, then squared three times.
    function automatic logic [15:0] env_entry(input int unsigned k);
        logic [63:0] z;
        logic [63:0] mag;
        logic [63:0] sum;
        logic [63:0] v;
        z   = (64'(3 * k) << 30) / ENV_DEN;
        mag = ONE_Q30;
        sum = ONE_Q30;
        for (int n = 1; n <= 10; n++) begin
            mag = ((mag * z) >> 30) / ENV_DIV[n];
            if ((n % 2) == 1) begin
                sum = sum - mag;
            end else begin
                sum = sum + mag;
            end
        end
        for (int n = 0; n < 3; n++) begin
            sum = (sum * sum + 64'd536870912) >> 30;
        end
        v = (sum * 64'd32768 + 64'd536870912) >> 30;
        return (v > 64'd65535) ? 16'hFFFF : v[15:0];
    endfunction

    logic [15:0] rom [ENV_N];

    for (genvar k = 0; k < ENV_N; k++) begin : g_rom
        assign rom[k] = env_entry(k);
    end

    logic [15:0] r_level;

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_level <= rom[i_addr];
        end
    end

    assign o_level = r_level;

endmodule

FILE: design/bsba_mix.sv
// ============================================================================
// bsba_mix
// Three-stage Q1.15 mixer: envelope square, envelope products, gains and sum.
// ============================================================================
module bsba_mix
    import bsba_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  t_mix_in            i_in,
    output logic               o_done,
    output logic signed [15:0] o_sample
);

    localparam logic signed [39:0] OCT_GAIN  = 40'sd13107;  // 0.4
    localparam logic signed [39:0] BASS_GAIN = 40'sd10486;  // 0.32
    localparam logic signed [39:0] ARP_GAIN  = 40'sd3932;   // 0.12

    // Q15 product scaling, rounded to nearest with ties away from zero.
    function automatic logic signed [39:0] rq(input logic signed [39:0] p);
        return (p + 40'sd16384 - 40'($unsigned(p[39]))) >>> 15;
    endfunction

    logic r_v1;
    logic r_v2;
    logic r_v3;

    logic signed [16:0] r1_env;
    logic signed [16:0] r1_env2;
    logic signed [16:0] r1_oct;
    logic signed [15:0] r1_sb;
    logic signed [15:0] r1_sa;

    logic signed [16:0] r2_be;
    logic signed [16:0] r2_ae;

    logic signed [15:0] r3_t1;
    logic signed [15:0] r3_t2;

    logic signed [16:0] env_s;
    logic signed [39:0] p_env2;
    logic signed [39:0] p_oct;
    logic signed [16:0] bsum;
    logic signed [39:0] p_be;
    logic signed [39:0] p_ae;
    logic signed [39:0] p_t1;
    logic signed [39:0] p_t2;

    assign env_s  = $signed({1'b0, i_in.env});
    assign p_env2 = rq(40'(env_s) * 40'(env_s));
    assign p_oct  = rq(40'(i_in.so) * OCT_GAIN);

    assign bsum   = 17'(r1_sb) + r1_oct;
    assign p_be   = rq(40'(bsum) * 40'(r1_env));
    assign p_ae   = rq(40'(r1_sa) * 40'(r1_env2));

    assign p_t1   = rq(40'(r2_be) * BASS_GAIN);
    assign p_t2   = rq(40'(r2_ae) * ARP_GAIN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Each stage loads only when its operands are valid, so the last stage
    // keeps its result until the next sample comes through.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r1_env  <= env_s;
            r1_env2 <= p_env2[16:0];
            r1_oct  <= p_oct[16:0];
            r1_sb   <= i_in.sb;
            r1_sa   <= i_in.sa;
        end
        if (r_v1) begin
            r2_be <= p_be[16:0];
            r2_ae <= p_ae[16:0];
        end
        if (r_v2) begin
            r3_t1 <= p_t1[15:0];
            r3_t2 <= p_t2[15:0];
        end
    end

    assign o_done   = r_v3;
    assign o_sample = r3_t1 + r3_t2;

endmodule

FILE: design/beat_sequenced_bass_arp_synth.sv
// ============================================================================
// beat_sequenced_bass_arp_synth
// Beat-sequenced bass and arpeggio loop synthesizer, one sample per request.
// ============================================================================
//
//  Channel   Dir   Handshake                     Payload
//  --------  ----  ----------------------------  --------------------------------
//  s_axis    in    i_s_axis_tvalid/o_s_axis_tready tdata[0] restart
//  m_axis    out   o_m_axis_tvalid/i_m_axis_tready tdata[15:0] sample, tlast loop end
//  cfg       in    i_cfg_wr_en                    i_cfg_idx, i_cfg_wr_data
//
// Between one acceptance and the next, a request goes through the phase multiplies,
// three back-to-back reads of the shared sine ROM, the mixer launch and three
// mixer stages, and it may wait in S_HOLD for the output register.
// Reset is synchronous and active low; it returns the beat position and the
// sample counter to zero and the configuration registers to their defaults.
// The ROMs hold constant contents and need no clearing pass.
// A finished sample waits in the output register while the next request is
// already being accepted; a second finished sample waits in the mixer's last
// stage until the output register frees up.
//
module beat_sequenced_bass_arp_synth
    import bsba_pkg::*;
#(
    parameter int unsigned SAMPLE_RATE    = SAMPLE_RATE_DEF,
    parameter int unsigned SINE_ADDR_BITS = SINE_ADDR_BITS_DEF,
    parameter int unsigned ENV_ADDR_BITS  = ENV_ADDR_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [S_TDATA_W-1:0]  i_s_axis_tdata,   // [0] restart, [7:1] zero

    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [M_TDATA_W-1:0]  o_m_axis_tdata,   // [15:0] sample
    output logic                  o_m_axis_tlast,   // last sample of the loop

    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wr_data
);

    // Phase increments round(f * 2^32 / SAMPLE_RATE), f in hertz, given in centihertz.
    localparam logic [63:0] PHASE_DEN = 64'(100) * 64'(SAMPLE_RATE);
    localparam logic [63:0] PHASE_RND = 64'(50) * 64'(SAMPLE_RATE);

    function automatic logic [31:0] phase_inc(input logic [31:0] centi);
        logic [63:0] q;
        q = ({centi, 32'd0} + PHASE_RND) / PHASE_DEN;
        return q[31:0];
    endfunction

    localparam logic [31:0] BASS_INC [8] = '{
        phase_inc(32'd5500), phase_inc(32'd5500), phase_inc(32'd6541), phase_inc(32'd4900),
        phase_inc(32'd5500), phase_inc(32'd7342), phase_inc(32'd6541), phase_inc(32'd4900)
    };
    localparam logic [31:0] ARP_INC [4] = '{
        phase_inc(32'd22000), phase_inc(32'd26163), phase_inc(32'd32963), phase_inc(32'd26163)
    };

    typedef enum logic [2:0] {
        S_IDLE,   // waiting for a request
        S_SB,     // sine ROM reads the bass phase
        S_SO,     // reads the octave phase, bass sine comes back
        S_SA,     // reads the arpeggio phase, octave sine comes back
        S_M0,     // arpeggio sine comes back, mixer starts
        S_WAIT,   // mixer at work
        S_HOLD    // result waits for the output register
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [31:0] r_beat_step;
    logic [10:0] r_loop_beats;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat_step  <= BEAT_STEP_RST;
            r_loop_beats <= LOOP_BEATS_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                REG_BEAT_STEP:  r_beat_step  <= i_cfg_wr_data;
                REG_LOOP_BEATS: r_loop_beats <= i_cfg_wr_data[10:0];
                default: ;
            endcase
        end
    end

    // Time state.
    logic [31:0] r_sample_count;
    logic [9:0]  r_beat_count;
    logic [31:0] r_beat_fraction;

    logic        accept;
    logic        restart;
    logic [31:0] eff_count;
    logic [9:0]  eff_beat;
    logic [31:0] eff_frac;
    logic [32:0] frac_sum;
    logic [10:0] next_beat;
    logic        last;
    logic [31:0] n_sample_count;
    logic [9:0]  n_beat_count;
    logic [31:0] n_beat_fraction;
    logic [31:0] bass_ph;
    logic [31:0] arp_ph;

    assign accept  = i_s_axis_tvalid && o_s_axis_tready;
    assign restart = i_s_axis_tdata[0];

    // A restart request clears the time state before its own sample is made.
    always_comb begin
        eff_count = restart ? 32'd0 : r_sample_count;
        eff_beat  = restart ? 10'd0 : r_beat_count;
        eff_frac  = restart ? 32'd0 : r_beat_fraction;

        frac_sum  = {1'b0, eff_frac} + {1'b0, r_beat_step};
        next_beat = {1'b0, eff_beat} + {10'd0, frac_sum[32]};
        last      = next_beat >= r_loop_beats;

        if (last) begin
            n_sample_count  = 32'd0;
            n_beat_count    = 10'd0;
            n_beat_fraction = 32'd0;
        end else begin
            n_sample_count  = eff_count + 32'd1;
            n_beat_count    = next_beat[9:0];
            n_beat_fraction = frac_sum[31:0];
        end

        bass_ph = 32'(eff_count * BASS_INC[eff_beat[2:0]]);
        arp_ph  = 32'(eff_count * ARP_INC[{eff_beat[0], eff_frac[31]}]);
    end

    // Shared sine ROM: one read per cycle, three per sample.
    logic [31:0]        r_bass_ph;
    logic [31:0]        r_arp_ph;
    logic [31:0]        sine_phase;
    logic signed [15:0] sine_value;

    always_comb begin
        case (r_state)
            S_SB:    sine_phase = r_bass_ph;
            S_SO:    sine_phase = {r_bass_ph[30:0], 1'b0};
            default: sine_phase = r_arp_ph;
        endcase
    end

    bsba_sine_rom #(
        .SINE_ADDR_BITS (SINE_ADDR_BITS)
    ) u_sine_rom (
        .i_clk   (i_clk),
        .i_phase (sine_phase),
        .o_value (sine_value)
    );

    // Envelope ROM, read once at acceptance; its output holds for the sample.
    logic [15:0] env_level;

    bsba_env_rom #(
        .ENV_ADDR_BITS (ENV_ADDR_BITS)
    ) u_env_rom (
        .i_clk   (i_clk),
        .i_rd_en (accept),
        .i_addr  (eff_frac[31 -: ENV_ADDR_BITS]),
        .o_level (env_level)
    );

    // Mixer.
    logic signed [15:0] r_sb;
    logic signed [15:0] r_so;
    logic               r_last;
    t_mix_in            mix_in;
    logic               mix_start;
    logic               mix_done;
    logic signed [15:0] mix_sample;

    assign mix_in.sb  = r_sb;
    assign mix_in.so  = r_so;
    assign mix_in.sa  = sine_value;
    assign mix_in.env = env_level;
    assign mix_start  = (r_state == S_M0);

    bsba_mix u_mix (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mix_start),
        .i_in     (mix_in),
        .o_done   (mix_done),
        .o_sample (mix_sample)
    );

    // Output register.
    logic                 r_m_tvalid;
    logic [M_TDATA_W-1:0] r_m_tdata;
    logic                 r_m_tlast;
    logic                 out_free;
    logic                 load_out;

    assign out_free = !r_m_tvalid || i_m_axis_tready;
    assign load_out = ((r_state == S_WAIT && mix_done) || r_state == S_HOLD) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_sample_count  <= 32'd0;
            r_beat_count    <= 10'd0;
            r_beat_fraction <= 32'd0;
            r_m_tvalid      <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_SB;
                    end
                end
                S_SB:   r_state <= S_SO;
                S_SO:   r_state <= S_SA;
                S_SA:   r_state <= S_M0;
                S_M0:   r_state <= S_WAIT;
                S_WAIT: begin
                    if (mix_done) begin
                        r_state <= load_out ? S_IDLE : S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (accept) begin
                r_sample_count  <= n_sample_count;
                r_beat_count    <= n_beat_count;
                r_beat_fraction <= n_beat_fraction;
            end

            if (load_out) begin
                r_m_tvalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_bass_ph <= bass_ph;
            r_arp_ph  <= arp_ph;
            r_last    <= last;
        end
        if (r_state == S_SO) begin
            r_sb <= sine_value;
        end
        if (r_state == S_SA) begin
            r_so <= sine_value;
        end
        if (load_out) begin
            r_m_tdata <= mix_sample;
            r_m_tlast <= r_last;
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_m_tvalid;
    assign o_m_axis_tdata  = r_m_tdata;
    assign o_m_axis_tlast  = r_m_tlast;

endmodule

FILE: design/bsba_checker.sv
// ============================================================================
// bsba_checker
// Port-level checks on the loop synthesizer, bound to the top level.
// ============================================================================
module bsba_checker
    import bsba_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_axis_tvalid,
    input logic                  o_s_axis_tready,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [M_TDATA_W-1:0]  o_m_axis_tdata,
    input logic                  o_m_axis_tlast
);

    logic       in_acc;
    logic       out_acc;
    logic [1:0] r_pending;

    assign in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_acc = o_m_axis_tvalid && i_m_axis_tready;

    // Requests accepted whose samples have not yet been taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 2'd0;
        end else begin
            r_pending <= r_pending + {1'b0, in_acc} - {1'b0, out_acc};
        end
    end

    // A held sample does not change while the sink stalls.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("output changed while stalled");

    // Every sample shown belongs to an accepted request.
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> r_pending != 2'd0)
        else $error("sample without a request");

    // At most one request in work and one waiting at the output.
    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending != 2'd3)
        else $error("too many requests outstanding");

    // One request at a time: the input closes right after an acceptance.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_s_axis_tready)
        else $error("input accepted while busy");

    // Reset leaves the block ready with no sample shown.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> o_s_axis_tready && !o_m_axis_tvalid)
        else $error("bad state after reset");

endmodule

bind beat_sequenced_bass_arp_synth bsba_checker u_bsba_checker (.*);

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Self-checking bench for the beat-sequenced bass and arpeggio synthesizer:
// restart requests go in on the slave stream, and every mixed sample that
// comes out is compared against a bit-exact predictor of the loop.
// ============================================================================
module tb_top;
    import bsba_pkg::*;

    // Build options of the block under test; the predictor uses the same ones.
    localparam int unsigned RATE      = SAMPLE_RATE_DEF;
    localparam int unsigned SINE_BITS = SINE_ADDR_BITS_DEF;
    localparam int unsigned ENV_BITS  = ENV_ADDR_BITS_DEF;
    localparam int unsigned SINE_N    = 1 << SINE_BITS;
    localparam int unsigned ENV_N     = 1 << ENV_BITS;

    // Fixed-point constants: pi and one in Q2.30, mixer gains in Q1.15.
    localparam longint unsigned PI_Q30  = 64'd3373259426;
    localparam longint unsigned ONE_Q30 = 64'd1 << 30;
    localparam int OCTAVE_GAIN = 13107;   // 0.4
    localparam int BASS_GAIN   = 10486;   // 0.32
    localparam int ARP_GAIN    = 3932;    // 0.12

    // Note frequencies in hundredths of a hertz.
    localparam int unsigned BASS_CENTI [8] = '{5500, 5500, 6541, 4900, 5500, 7342, 6541, 4900};
    localparam int unsigned ARP_CENTI  [4] = '{22000, 26163, 32963, 26163};

    // The settle margin covers any sample still in flight after the last
    // expected one has arrived.
    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT   = 4000;
    localparam int RANDOM_ITEMS  = 470;

    typedef struct {
        logic [15:0] mix;
        logic        last;
    } loop_out_t;

    // ------------------------------------------------------------------------
    // Loop predictor. It keeps its own copy of the beat position, the sample
    // counter and both registers, and queues the sample that each accepted
    // request must produce.
    // ------------------------------------------------------------------------
    class loop_sample_book;
        bit [15:0]   quarter_sine [SINE_N];
        bit [15:0]   decay_lut [ENV_N];
        bit [31:0]   beat_inc;
        bit [10:0]   loop_len;
        bit [31:0]   smp_idx;
        bit [9:0]    beat_num;
        bit [31:0]   frac_pos;
        loop_out_t   due_samples [$];
        int          errors;

        function new();
            beat_inc  = BEAT_STEP_RST;
            loop_len  = LOOP_BEATS_RST;
            smp_idx   = 0;
            beat_num  = 0;
            frac_pos  = 0;
            errors    = 0;
            build_tables();
        endfunction

        // Quarter-wave sine by a fifteenth-order Taylor series, and exp(-3x)
        // as exp(-3x/8) squared three times, both in 64-bit integer arithmetic.
        function void build_tables();
            longint unsigned x, x2, z, mag, sum, v;
            int unsigned k, n;
            for (k = 0; k < SINE_N; k++) begin
                x   = (PI_Q30 * (64'd2 * k + 64'd1) + 64'd2 * SINE_N) / (64'd4 * SINE_N);
                x2  = (x * x) >> 30;
                mag = x;
                sum = x;
                for (n = 1; n <= 7; n++) begin
                    mag = ((mag * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
                    if (n[0]) sum -= mag;
                    else      sum += mag;
                end
                v = (sum * 64'd32768 + (64'd1 << 29)) >> 30;
                quarter_sine[k] = (v > 64'd32767) ? 16'd32767 : v[15:0];
            end
            for (k = 0; k < ENV_N; k++) begin
                z   = (longint'(3 * k) << 30) / (64'd8 * ENV_N);
                mag = ONE_Q30;
                sum = ONE_Q30;
                for (n = 1; n <= 10; n++) begin
                    mag = ((mag * z) >> 30) / longint'(n);
                    if (n[0]) sum -= mag;
                    else      sum += mag;
                end
                for (n = 0; n < 3; n++)
                    sum = (sum * sum + (64'd1 << 29)) >> 30;
                v = (sum * 64'd32768 + (64'd1 << 29)) >> 30;
                decay_lut[k] = (v > 64'd65535) ? 16'hFFFF : v[15:0];
            end
        endfunction

        function bit [31:0] phase_step(int unsigned centi);
            longint unsigned num;
            num = (longint'(centi) << 32) + 64'd50 * RATE;
            return 32'(num / (64'd100 * RATE));
        endfunction

        // Quadrants 1 and 3 read the table backwards, quadrants 2 and 3 negate.
        function int sine_of(bit [31:0] phase);
            bit [1:0]    quad;
            int unsigned idx;
            int          v;
            quad = phase[31:30];
            idx  = (phase >> (30 - SINE_BITS)) & (SINE_N - 1);
            if (quad[0]) idx = SINE_N - 1 - idx;
            v = int'(quarter_sine[idx]);
            return quad[1] ? -v : v;
        endfunction

        // Q1.15 product, rounded to nearest with ties away from zero.
        function int qmul(int a, int b);
            longint          p;
            longint unsigned m;
            longint          r;
            p = longint'(a) * longint'(b);
            m = (p < 0) ? longint'(-p) : longint'(p);
            r = longint'((m + 64'd16384) >> 15);
            return int'((p < 0) ? -r : r);
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_BEAT_STEP) beat_inc = data;
            else                      loop_len = data[10:0];
        endfunction

        function int pending();
            return due_samples.size();
        endfunction

        function void note_request(bit restart);
            bit [31:0]   bass_phase, octave_phase, arp_phase, next_frac;
            int unsigned next_beat;
            int          env, env2, sb, so, sa, bsum, t1, t2, mix;
            loop_out_t   due;
            if (restart) begin
                smp_idx   = 0;
                beat_num  = 0;
                frac_pos  = 0;
            end
            // The arpeggio moves on every half beat: beat LSB and fraction MSB.
            bass_phase   = smp_idx * phase_step(BASS_CENTI[beat_num[2:0]]);
            octave_phase = bass_phase << 1;
            arp_phase    = smp_idx * phase_step(ARP_CENTI[{beat_num[0], frac_pos[31]}]);
            sb = sine_of(bass_phase);
            so = sine_of(octave_phase);
            sa = sine_of(arp_phase);

            env  = int'(decay_lut[frac_pos >> (32 - ENV_BITS)]);
            env2 = qmul(env, env);
            bsum = sb + qmul(so, OCTAVE_GAIN);
            t1   = qmul(qmul(bsum, env), BASS_GAIN);
            t2   = qmul(qmul(sa, env2), ARP_GAIN);
            mix  = t1 + t2;

            // A carry out of the fraction is a new beat; reaching the loop
            // length flags this sample and sends the loop back to its start.
            next_frac = frac_pos + beat_inc;
            next_beat = beat_num + ((next_frac < frac_pos) ? 1 : 0);
            due.mix   = mix[15:0];
            due.last  = (next_beat >= loop_len);
            if (due.last) begin
                smp_idx   = 0;
                beat_num  = 0;
                frac_pos  = 0;
            end else begin
                smp_idx   = smp_idx + 1;
                beat_num  = next_beat[9:0];
                frac_pos  = next_frac;
            end
            due_samples.push_back(due);
        endfunction

        function void check_sample(logic [15:0] mix, logic last);
            loop_out_t due;
            if (due_samples.size() == 0) begin
                $display("%0t unexpected sample: expected none, actual %0d last %0b",
                         $time, $signed(mix), last);
                errors++;
                return;
            end
            due = due_samples.pop_front();
            if (mix !== due.mix) begin
                $display("%0t sample mismatch: expected %0d actual %0d",
                         $time, $signed(due.mix), $signed(mix));
                errors++;
            end
            if (last !== due.last) begin
                $display("%0t loop end mismatch: expected %0b actual %0b",
                         $time, due.last, last);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block under test.
    // ------------------------------------------------------------------------
    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [S_TDATA_W-1:0]  i_s_axis_tdata;    // [0] restart, [7:1] zero
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    logic [M_TDATA_W-1:0]  o_m_axis_tdata;    // [15:0] sample
    logic                  o_m_axis_tlast;    // last sample of the loop
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wr_data;

    beat_sequenced_bass_arp_synth u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wr_data   (i_cfg_wr_data)
    );

    loop_sample_book book;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Sender side. A request is held until the block takes it; requests come
    // in bursts of random length, and the gap after a burst is sometimes zero,
    // which gives stretches where the block is never starved.
    // ------------------------------------------------------------------------
    bit req_up;
    int burst_left;

    task automatic send_request(bit restart);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {{(S_TDATA_W-1){1'b0}}, restart};
        req_up = 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        book.note_request(restart);
    endtask

    task automatic feed(bit restart);
        int gap;
        send_request(restart);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
            if (gap > 0) begin
                i_s_axis_tvalid <= 1'b0;
                req_up = 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Registers may only change while nothing is in flight: every predicted
    // sample must have come out, plus a margin for the block's pipeline.
    task automatic wait_idle();
        if (req_up) begin
            i_s_axis_tvalid <= 1'b0;
            req_up = 1'b0;
        end
        while (book.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // The write enable stays high across back-to-back writes and is lowered
    // by the caller once all writes are done.
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_idx     <= idx;
        i_cfg_wr_data <= data;
        @(posedge i_clk);
        book.set_reg(idx, data);
    endtask

    task automatic configure(bit wr_step, logic [31:0] beat_step, bit wr_loop,
                             logic [31:0] loop_data);
        wait_idle();
        if (wr_step) cfg_write(REG_BEAT_STEP, beat_step);
        if (wr_loop) cfg_write(REG_LOOP_BEATS, loop_data);
        i_cfg_wr_en <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Receiver side. Every accepted sample is checked in order. The ready line
    // switches between several stall patterns of random duration.
    // ------------------------------------------------------------------------
    int ready_mode;
    int hold_left;
    int ready_phase;

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            book.check_sample(o_m_axis_tdata, o_m_axis_tlast);
        if (hold_left <= 0) begin
            ready_mode = $urandom_range(0, 3);
            hold_left  = $urandom_range(16, 160);
        end
        hold_left--;
        ready_phase++;
        case (ready_mode)
            0: i_m_axis_tready <= 1'b1;
            1: i_m_axis_tready <= 1'($urandom_range(0, 1));
            2: i_m_axis_tready <= (ready_phase % 5 == 0);
            default: i_m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // ------------------------------------------------------------------------
    // Watchdog: too many cycles in a row without any accepted transfer on
    // either stream means the block has hung.
    // ------------------------------------------------------------------------
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("beat_sequenced_bass_arp_synth test failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int          sent;
        int          phase_len;
        int          n;
        bit          wr_step, wr_loop;
        logic [31:0] beat_step;
        logic [10:0] loop_len;
        logic [31:0] loop_data;

        book            = new();
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_m_axis_tready <= 1'b0;
        i_cfg_wr_en     <= 1'b0;
        i_cfg_idx       <= REG_BEAT_STEP;
        i_cfg_wr_data   <= '0;
        req_up          = 1'b0;
        burst_left      = 4;
        hold_left       = 0;
        ready_phase     = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset defaults, with a restart in the middle of the run.
        feed(1'b0);
        feed(1'b0);
        feed(1'b0);
        feed(1'b1);
        feed(1'b0);

        // Half a beat per sample and a one-beat loop: every second sample
        // ends the loop.
        configure(1'b1, 32'h8000_0000, 1'b1, 32'd1);
        repeat (4) feed(1'b0);

        // A zero loop length flags every sample.
        configure(1'b0, 32'd0, 1'b1, 32'd0);
        repeat (3) feed(1'b0);

        // Largest step and longest loop; the upper write bits are don't-care.
        configure(1'b1, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
        feed(1'b1);
        repeat (5) feed(1'b0);

        // Loop shortened below the current beat: the next sample ends it.
        configure(1'b0, 32'd0, 1'b1, 32'd2);
        repeat (2) feed(1'b0);

        // Zero step: the beat position stands still while the tones run on.
        configure(1'b1, 32'd0, 1'b1, 32'd16);
        feed(1'b1);
        repeat (2) feed(1'b0);

        // Random phases. Each one may change either register and then runs a
        // stretch of mostly plain requests with the odd restart; the beat
        // position carries over from one phase to the next.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       beat_step = 32'd0;
                1:       beat_step = 32'hFFFF_FFFF;
                2:       beat_step = 32'h8000_0000;
                3, 4:    beat_step = $urandom;
                5:       beat_step = 32'd1;
                default: beat_step = $urandom_range(20000, 20000000);
            endcase
            case ($urandom_range(0, 9))
                0:       loop_len = 11'd0;
                1:       loop_len = 11'd1024;
                2:       loop_len = 11'($urandom_range(1025, 2047));
                3:       loop_len = 11'd2047;
                4:       loop_len = 11'($urandom_range(17, 1023));
                default: loop_len = 11'($urandom_range(1, 16));
            endcase
            loop_data = {21'($urandom_range(0, 1) ? $urandom : 0), loop_len};
            wr_step   = ($urandom_range(0, 3) != 0);
            wr_loop   = ($urandom_range(0, 3) != 0);
            configure(wr_step, beat_step, wr_loop, loop_data);
            phase_len = $urandom_range(8, 60);
            for (n = 0; n < phase_len; n++)
                feed($urandom_range(0, 15) == 0);
            sent += phase_len;
        end

        wait_idle();
        if (book.errors == 0)
            $display("beat_sequenced_bass_arp_synth test passed");
        else
            $display("beat_sequenced_bass_arp_synth test failed");
        $finish;
    end

endmodule
